[sv/dfc_pkg.sv]
// ----------------------------------------------------------------------------
// dfc_pkg
// shared types and constants of the dco frequency calibrator
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

  localparam int CAP_W   = 16;
  localparam int TRIM_W  = 8;
  localparam int CTRL_W  = 8;
  localparam int RANGE_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [TRIM_W-1:0]  TRIM_RESET   = 8'h90;
  localparam logic [CTRL_W-1:0]  CTRL_RESET   = 8'h8B;
  localparam logic [CAP_W-1:0]   TARGET_RESET = 16'd126;
  localparam logic [CAP_W-1:0]   LIMIT_RESET  = 16'd1000;
  localparam logic [TRIM_W-1:0]  TRIM_MAX     = 8'hFF;
  localparam logic [TRIM_W-1:0]  TRIM_MIN     = 8'h00;
  localparam logic [RANGE_W-1:0] RANGE_MAX    = 3'd7;
  localparam logic [RANGE_W-1:0] RANGE_MIN    = 3'd0;
  localparam logic [CAP_W-1:0]   TRIES_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_CAPTURE = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_COUNT = 2'd0,
    REG_TRY_LIMIT    = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ADJUSTING    = 3'd0,
    ST_LOCKED       = 3'd1,
    ST_GAVE_TRIES   = 3'd2,
    ST_GAVE_TIMEOUT = 3'd3,
    ST_IDLE         = 3'd4
  } status_t;

  typedef struct packed {
    logic [TRIM_W-1:0] trim_value;
    logic [CTRL_W-1:0] clock_control;
    status_t           status;
  } result_t;

endpackage

`default_nettype wire

[sv/dco_frequency_calibrator_unit.sv]
// ----------------------------------------------------------------------------
// dco_frequency_calibrator_unit
// oscillator trim loop with config registers and a two-entry result buffer
// ----------------------------------------------------------------------------
// an accepted word's result is registered into the output word, or into the skid word while the output word is stalled
// one word per cycle while in_stall is low; the state update is combinational and registered on accept
// in_stall rises only when both result registers are full
// reset: trim 0x90, control 0x8B, loop idle, target 126, try limit 1000
`default_nettype none

module dco_frequency_calibrator_unit
  import dfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_action,
  input  wire logic [CAP_W-1:0]     in_captured,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [TRIM_W-1:0]         out_trim_value,
  output logic [CTRL_W-1:0]         out_clock_control,
  output logic [2:0]                out_status,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAP_W-1:0]     cfg_data
);

  logic [CAP_W-1:0] target_r;
  logic [CAP_W-1:0] limit_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  result_t          out_r;
  result_t          skid_r;
  result_t          res;
  logic             accept_in;
  logic             out_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept_in = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_COUNT: target_r <= cfg_data;
        REG_TRY_LIMIT:    limit_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dfc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (accept_in),
    .action       (in_action),
    .captured     (in_captured),
    .target_count (target_r),
    .try_limit    (limit_r),
    .result       (res)
  );

  // skid word always sits behind the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept_in) begin
      out_valid_r <= 1'b1;
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trim_value    = out_r.trim_value;
  assign out_clock_control = out_r.clock_control;
  assign out_status        = out_r.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in |=> out_valid_r)
    else $error("accepted word produced no result");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && skid_valid_r) |=> (out_valid_r && !skid_valid_r))
    else $error("skid word lost on drain");

endmodule

`default_nettype wire

[sv/dfc_core.sv]
// ----------------------------------------------------------------------------
// dfc_core
// trim loop state and its per-word update, result formed in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_core
  import dfc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire logic [1:0]       action,
  input  wire logic [CAP_W-1:0] captured,
  input  wire logic [CAP_W-1:0] target_count,
  input  wire logic [CAP_W-1:0] try_limit,
  output result_t               result
);

  logic [TRIM_W-1:0] trim_r, trim_nxt;
  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [TRIM_W-1:0] trim_fb_r, trim_fb_nxt;
  logic [CTRL_W-1:0] ctrl_fb_r, ctrl_fb_nxt;
  logic [CAP_W-1:0]  prev_r, prev_nxt;
  logic [CAP_W-1:0]  tries_r, tries_nxt;
  logic              running_r, running_nxt;

  logic [CAP_W-1:0]  diff;
  logic [CAP_W:0]    tries_inc;
  logic [TRIM_W-1:0] trim_dn, trim_up;
  status_t           status;

  assign diff      = captured - prev_r;
  assign tries_inc = {1'b0, tries_r} + {{CAP_W{1'b0}}, 1'b1};
  assign trim_dn   = trim_r - {{(TRIM_W-1){1'b0}}, 1'b1};
  assign trim_up   = trim_r + {{(TRIM_W-1){1'b0}}, 1'b1};

  always_comb begin
    trim_nxt    = trim_r;
    ctrl_nxt    = ctrl_r;
    trim_fb_nxt = trim_fb_r;
    ctrl_fb_nxt = ctrl_fb_r;
    prev_nxt    = prev_r;
    tries_nxt   = tries_r;
    running_nxt = running_r;
    status      = running_r ? ST_ADJUSTING : ST_IDLE;
    case (action)
      ACT_START: begin
        running_nxt = 1'b1;
        prev_nxt    = '0;
        tries_nxt   = '0;
        status      = ST_ADJUSTING;
      end
      ACT_CAPTURE: begin
        if (running_r) begin
          prev_nxt  = captured;
          tries_nxt = tries_inc[CAP_W] ? TRIES_MAX : tries_inc[CAP_W-1:0];
          if (tries_inc > {1'b0, try_limit}) begin
            trim_nxt    = trim_fb_r;
            ctrl_nxt    = ctrl_fb_r;
            running_nxt = 1'b0;
            status      = ST_GAVE_TRIES;
          end else if (diff == target_count) begin
            trim_fb_nxt = trim_r;
            ctrl_fb_nxt = ctrl_r;
            running_nxt = 1'b0;
            status      = ST_LOCKED;
          end else if (diff > target_count) begin
            // running fast: step trim down, borrow from range on wrap
            trim_nxt = trim_dn;
            if (trim_dn == TRIM_MAX && ctrl_r[RANGE_W-1:0] != RANGE_MIN)
              ctrl_nxt = ctrl_r - {{(CTRL_W-1){1'b0}}, 1'b1};
            status = ST_ADJUSTING;
          end else begin
            trim_nxt = trim_up;
            if (trim_up == TRIM_MIN && ctrl_r[RANGE_W-1:0] != RANGE_MAX)
              ctrl_nxt = ctrl_r + {{(CTRL_W-1){1'b0}}, 1'b1};
            status = ST_ADJUSTING;
          end
        end
      end
      ACT_TIMEOUT: begin
        if (running_r) begin
          trim_nxt    = trim_fb_r;
          ctrl_nxt    = ctrl_fb_r;
          running_nxt = 1'b0;
          status      = ST_GAVE_TIMEOUT;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.trim_value    = trim_nxt;
  assign result.clock_control = ctrl_nxt;
  assign result.status        = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r    <= TRIM_RESET;
      ctrl_r    <= CTRL_RESET;
      trim_fb_r <= TRIM_RESET;
      ctrl_fb_r <= CTRL_RESET;
      prev_r    <= '0;
      tries_r   <= '0;
      running_r <= 1'b0;
    end else if (take) begin
      trim_r    <= trim_nxt;
      ctrl_r    <= ctrl_nxt;
      trim_fb_r <= trim_fb_nxt;
      ctrl_fb_r <= ctrl_fb_nxt;
      prev_r    <= prev_nxt;
      tries_r   <= tries_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

`default_nettype wire
